FILE: rtl/packet_framer_with_sum_checksum_macros.svh
// Assertion macros for the packet framer RTL
`ifndef PACKET_FRAMER_WITH_SUM_CHECKSUM_MACROS_SVH
`define PACKET_FRAMER_WITH_SUM_CHECKSUM_MACROS_SVH

// Same-cycle implication, checked on clk and disabled during reset
`define PFSC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk and disabled during reset
`define PFSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/pfsc_pkg.sv
// Types and constants of the packet framer with sum checksum
`default_nettype none

package pfsc_pkg;

	// Item kinds carried on the input tuser
	localparam logic KIND_START   = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	// Beat positions inside a start item (header bytes; a checksum follows only for an empty frame)
	localparam logic [2:0] BEAT_PREFIX  = 3'd0;
	localparam logic [2:0] BEAT_SND_HI  = 3'd1;
	localparam logic [2:0] BEAT_SND_LO  = 3'd2;
	localparam logic [2:0] BEAT_RCV_HI  = 3'd3;
	localparam logic [2:0] BEAT_RCV_LO  = 3'd4;
	localparam logic [2:0] BEAT_LEN     = 3'd5;
	localparam logic [2:0] BEAT_FIRST   = 3'd0;

	// One input item as held in the input stage
	typedef struct packed {
		logic        kind;
		logic [15:0] sender_address;
		logic [15:0] receiver_address;
		logic [6:0]  payload_length;
		logic [7:0]  data_byte;
	} item_t;

	// One output beat
	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_end;
		logic       stray_error;
		logic       last_of_run;
	} beat_t;

endpackage

`default_nettype wire

FILE: rtl/pfsc_seq.sv
// Beat sequencer: frame state and the byte sent on each beat of the held item
`default_nettype none

module pfsc_seq #(
	parameter int MAX_PAYLOAD = 120
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire pfsc_pkg::item_t item,
	input  wire logic [7:0]    prefix_byte,
	input  wire logic          step,
	output pfsc_pkg::beat_t    beat
);
	import pfsc_pkg::*;

	localparam logic [7:0] MAX_LEN8 = 8'(MAX_PAYLOAD);
	localparam logic [6:0] MAX_LEN7 = 7'(MAX_PAYLOAD);

	logic [2:0] idx_q;
	logic [6:0] rem_q;
	logic [7:0] sum_q;
	logic       open_q;

	logic [6:0] len_sat;
	logic       stray;
	logic [7:0] sum_start;

	// Clamp length, spot payload bytes with no open frame and form the start checksum
	always_comb begin
		len_sat   = ({1'b0, item.payload_length} > MAX_LEN8) ? MAX_LEN7 : item.payload_length;
		stray     = !open_q || (rem_q == 7'd0);
		sum_start = item.sender_address[7:0] + item.receiver_address[7:0] + {1'b0, len_sat};
	end

	// Select the byte and flags of the current beat
	always_comb begin
		beat = '0;
		unique case (item.kind)
			KIND_START: begin
				unique case (idx_q)
					BEAT_PREFIX: beat.out_byte = prefix_byte;
					BEAT_SND_HI: beat.out_byte = item.sender_address[15:8];
					BEAT_SND_LO: beat.out_byte = item.sender_address[7:0];
					BEAT_RCV_HI: beat.out_byte = item.receiver_address[15:8];
					BEAT_RCV_LO: beat.out_byte = item.receiver_address[7:0];
					BEAT_LEN: begin
						beat.out_byte    = {1'b0, len_sat};
						beat.last_of_run = (len_sat != 7'd0);
					end
					default: begin
						// checksum of an empty frame
						beat.out_byte    = sum_q;
						beat.frame_end   = 1'b1;
						beat.last_of_run = 1'b1;
					end
				endcase
			end
			default: begin
				if (idx_q == BEAT_FIRST) begin
					if (stray) begin
						beat.stray_error = 1'b1;
						beat.last_of_run = 1'b1;
					end else begin
						beat.out_byte    = item.data_byte;
						beat.last_of_run = (rem_q != 7'd1);
					end
				end else begin
					// checksum after the final payload byte
					beat.out_byte    = sum_q;
					beat.frame_end   = 1'b1;
					beat.last_of_run = 1'b1;
				end
			end
		endcase
	end

	// Advance beat index and frame state on each emitted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= BEAT_FIRST;
			rem_q  <= '0;
			sum_q  <= '0;
			open_q <= 1'b0;
		end else if (step) begin
			idx_q <= beat.last_of_run ? BEAT_FIRST : idx_q + 3'd1;
			if (idx_q == BEAT_FIRST) begin
				if (item.kind == KIND_START) begin
					sum_q  <= sum_start;
					rem_q  <= len_sat;
					open_q <= (len_sat != 7'd0);
				end else if (!stray) begin
					sum_q <= sum_q + item.data_byte;
					rem_q <= rem_q - 7'd1;
					if (rem_q == 7'd1) begin
						open_q <= 1'b0;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/packet_framer_with_sum_checksum.sv
// Path: an accepted item is held in the input stage, and each of its beats passes
// through the output beat register, from which it can be taken.
// Throughput: one beat per cycle while the output is taken; a payload byte
// gives one beat (two when it closes the frame), a start item six beats (seven for
// an empty frame). A new item can be taken as the last beat of the held one is sent.
// Reset: arst_n clears the frame state, the prefix register and all valids.
`default_nettype none

module packet_framer_with_sum_checksum #(
	parameter int MAX_PAYLOAD = 120
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data,     // prefix_byte
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [15:0] sender_address, [31:16] receiver_address, [38:32] payload_length,
	// [46:39] data_byte, [47] zero
	input  wire logic [47:0] s_axis_tdata,
	input  wire logic [0:0]  s_axis_tuser,  // [0] kind
	// output stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // [7:0] out_byte
	output logic [1:0]       m_axis_tuser,  // [0] frame_end, [1] stray_error
	output logic             m_axis_tlast   // last_of_run
);
	import pfsc_pkg::*;

	logic [7:0] prefix_q;
	item_t      item_s1;
	logic       valid_s1;
	beat_t      beat;
	beat_t      beat_q;
	logic       m_valid_q;
	logic       out_load;
	logic       step;
	logic       done;

	// Prefix register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= '0;
		end else if (cfg_valid) begin
			prefix_q <= cfg_data;
		end
	end

	// Handshake between the input stage and the output register
	assign out_load      = !m_valid_q || m_axis_tready;
	assign step          = valid_s1 && out_load;
	assign done          = step && beat.last_of_run;
	assign s_axis_tready = !valid_s1 || done;

	// Input stage: hold the item until its last beat leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1.kind             <= s_axis_tuser[0];
			item_s1.sender_address   <= s_axis_tdata[15:0];
			item_s1.receiver_address <= s_axis_tdata[31:16];
			item_s1.payload_length   <= s_axis_tdata[38:32];
			item_s1.data_byte        <= s_axis_tdata[46:39];
		end
	end

	pfsc_seq #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_s1),
		.prefix_byte (prefix_q),
		.step        (step),
		.beat        (beat)
	);

	// Output register: load a beat whenever the slot is free or drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= step;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			beat_q <= beat;
		end
	end

	assign m_axis_tvalid   = m_valid_q;
	assign m_axis_tdata    = beat_q.out_byte;
	assign m_axis_tuser[0] = beat_q.frame_end;
	assign m_axis_tuser[1] = beat_q.stray_error;
	assign m_axis_tlast    = beat_q.last_of_run;

`include "packet_framer_with_sum_checksum_macros.svh"

	// A stray beat is a lone zero byte that ends its run
	`PFSC_ASSERT_NOW(a_stray_beat, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast && (m_axis_tdata == 8'd0) && !m_axis_tuser[0], "stray beat malformed")

	// The checksum beat always ends the run of its item
	`PFSC_ASSERT_NOW(a_end_is_last, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast, "frame end without tlast")

	// An item stays in the input stage until its last beat is sent
	`PFSC_ASSERT_NEXT(a_item_held, step && !beat.last_of_run, valid_s1, "item dropped before last beat")

endmodule

`default_nettype wire

FILE: verif/tb_packet_framer_with_sum_checksum.sv
// Self-checking testbench for the packet framer: directed and random frames under stream backpressure
`timescale 1ns / 1ps

module tb_packet_framer_with_sum_checksum;

	localparam int FRAME_MAX_PAYLOAD = 120;
	localparam int SETTLE_CYCLES     = 8;
	localparam int CYCLE_LIMIT       = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = 8'h00;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic [0:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	// Framer model state, mirrors the block's configuration and frame state
	logic [7:0] prefix_model = 8'h00;
	logic [6:0] bytes_left = '0;
	logic [7:0] frame_sum = '0;
	logic       frame_is_open = 1'b0;

	pfsc_pkg::item_t item_queue[$];
	pfsc_pkg::beat_t frame_bytes_due[$];
	pfsc_pkg::item_t item_on_bus;

	int unsigned items_queued = 0;
	int unsigned items_taken = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	packet_framer_with_sum_checksum #(
		.MAX_PAYLOAD(FRAME_MAX_PAYLOAD)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void push_frame_byte(input logic [7:0] b, input logic fend,
			input logic err, input logic last);
		pfsc_pkg::beat_t bt;
		bt.out_byte    = b;
		bt.frame_end   = fend;
		bt.stray_error = err;
		bt.last_of_run = last;
		frame_bytes_due.push_back(bt);
	endfunction

	// Work out the output bytes that one accepted item causes
	function automatic void predict_frame_bytes(input pfsc_pkg::item_t it);
		logic [6:0] len;
		if (it.kind == pfsc_pkg::KIND_START) begin
			len = (it.payload_length > FRAME_MAX_PAYLOAD) ? 7'(FRAME_MAX_PAYLOAD)
				: it.payload_length;
			frame_sum  = it.sender_address[7:0] + it.receiver_address[7:0] + {1'b0, len};
			bytes_left = len;
			push_frame_byte(prefix_model, 1'b0, 1'b0, 1'b0);
			push_frame_byte(it.sender_address[15:8], 1'b0, 1'b0, 1'b0);
			push_frame_byte(it.sender_address[7:0], 1'b0, 1'b0, 1'b0);
			push_frame_byte(it.receiver_address[15:8], 1'b0, 1'b0, 1'b0);
			push_frame_byte(it.receiver_address[7:0], 1'b0, 1'b0, 1'b0);
			push_frame_byte({1'b0, len}, 1'b0, 1'b0, len != 0);
			// empty frame closes at once with its checksum
			if (len == 0) begin
				push_frame_byte(frame_sum, 1'b1, 1'b0, 1'b1);
				frame_is_open = 1'b0;
			end else begin
				frame_is_open = 1'b1;
			end
		end else if (!frame_is_open || bytes_left == 0) begin
			// drop a stray payload byte and flag it
			push_frame_byte(8'h00, 1'b0, 1'b1, 1'b1);
		end else begin
			frame_sum  = frame_sum + it.data_byte;
			bytes_left = bytes_left - 7'd1;
			if (bytes_left == 0) begin
				push_frame_byte(it.data_byte, 1'b0, 1'b0, 1'b0);
				push_frame_byte(frame_sum, 1'b1, 1'b0, 1'b1);
				frame_is_open = 1'b0;
			end else begin
				push_frame_byte(it.data_byte, 1'b0, 1'b0, 1'b1);
			end
		end
	endfunction

	// Drive input beats from the item queue, predicting each accepted one
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_frame_bytes(item_on_bus);
				items_taken++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (item_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					item_on_bus = item_queue.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {1'b0, item_on_bus.data_byte, item_on_bus.payload_length,
						item_on_bus.receiver_address, item_on_bus.sender_address};
					s_axis_tuser  <= item_on_bus.kind;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(input string what, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// Compare each output beat with the oldest predicted byte
	always @(posedge clk) begin
		pfsc_pkg::beat_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (frame_bytes_due.size() == 0) begin
					$display("%0t: unexpected beat, expected none, actual byte 0x%0h user %b last %b",
						$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
					mismatches++;
				end else begin
					want = frame_bytes_due.pop_front();
					check_field("out_byte", want.out_byte, m_axis_tdata);
					check_field("frame_end", want.frame_end, m_axis_tuser[0]);
					check_field("stray_error", want.stray_error, m_axis_tuser[1]);
					check_field("last_of_run", want.last_of_run, m_axis_tlast);
				end
			end
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic queue_start(input logic [15:0] snd, input logic [15:0] rcv,
			input logic [6:0] len);
		pfsc_pkg::item_t it;
		it = '0;
		it.kind             = pfsc_pkg::KIND_START;
		it.sender_address   = snd;
		it.receiver_address = rcv;
		it.payload_length   = len;
		it.data_byte        = 8'($urandom_range(0, 255));
		item_queue.push_back(it);
		items_queued++;
	endtask

	task automatic queue_payload(input logic [7:0] d);
		pfsc_pkg::item_t it;
		it = '0;
		it.kind             = pfsc_pkg::KIND_PAYLOAD;
		it.sender_address   = 16'($urandom_range(0, 65535));
		it.receiver_address = 16'($urandom_range(0, 65535));
		it.payload_length   = 7'($urandom_range(0, 127));
		it.data_byte        = d;
		item_queue.push_back(it);
		items_queued++;
	endtask

	// Wait for every queued item to go in and every predicted byte to come out
	task automatic drain_frames();
		while (items_taken != items_queued || frame_bytes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_prefix(input logic [7:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid    <= 1'b0;
		prefix_model = v;
	endtask

	// Mostly well-formed frames with random content; some strays and cut-off frames
	task automatic queue_random_traffic(input int budget);
		int n;
		int len;
		int sat;
		int sends;
		int k;
		n = 0;
		while (n < budget) begin
			if ($urandom_range(0, 99) < 8) begin
				queue_payload(8'($urandom_range(0, 255)));
				n++;
			end else begin
				if ($urandom_range(0, 9) == 0)
					len = $urandom_range(9, 127);
				else
					len = $urandom_range(0, 8);
				sat = (len > FRAME_MAX_PAYLOAD) ? FRAME_MAX_PAYLOAD : len;
				sends = sat;
				// abandon long frames early to keep the run short
				if (sat > 12)
					sends = $urandom_range(0, 6);
				else if (sat > 0 && $urandom_range(0, 9) == 0)
					sends = $urandom_range(0, sat - 1);
				queue_start(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
					7'(len));
				n++;
				for (k = 0; k < sends; k++) begin
					queue_payload(8'($urandom_range(0, 255)));
					n++;
				end
				if ($urandom_range(0, 9) == 0) begin
					queue_payload(8'($urandom_range(0, 255)));
					n++;
				end
			end
		end
	endtask

	initial begin
		int k;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: strays, empty frame, saturation, abandoned frames, max length
		write_prefix(8'hFF);
		queue_payload(8'hFF);
		queue_start(16'hFFFF, 16'hFFFF, 7'd0);
		queue_start(16'h0000, 16'h0000, 7'd1);
		queue_payload(8'h00);
		queue_start(16'h1234, 16'hABCD, 7'd127);
		queue_payload(8'hAA);
		queue_start(16'hA5A5, 16'h5A5A, 7'd121);
		queue_payload(8'h55);
		queue_start(16'h8001, 16'h0180, 7'd3);
		queue_payload(8'hFF);
		queue_payload(8'h80);
		queue_payload(8'h01);
		queue_payload(8'h7F);
		queue_start(16'h00FF, 16'hFF00, 7'd120);
		queue_payload(8'h00);
		queue_start(16'h0102, 16'h0304, 7'd2);
		queue_payload(8'hFE);
		queue_payload(8'hFF);
		queue_payload(8'h00);
		drain_frames();

		// Phase: no idling, one full-length frame, then random traffic
		write_prefix(8'h00);
		queue_start(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 7'd120);
		for (k = 0; k < FRAME_MAX_PAYLOAD; k++)
			queue_payload(8'($urandom_range(0, 255)));
		queue_random_traffic(20);
		drain_frames();

		// Phase: sender mostly idle
		send_idle_pct  = 78;
		recv_stall_pct = 0;
		write_prefix(8'($urandom_range(1, 254)));
		queue_random_traffic(60);
		drain_frames();

		// Phase: receiver mostly stalled, with a full pause halfway
		send_idle_pct  = 0;
		recv_stall_pct = 78;
		write_prefix(8'h80);
		queue_random_traffic(30);
		drain_frames();
		queue_random_traffic(30);
		drain_frames();

		// Phase: both sides idle now and then
		send_idle_pct  = 18;
		recv_stall_pct = 18;
		write_prefix(8'h7F);
		queue_random_traffic(60);
		drain_frames();

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: packet_framer_with_sum_checksum.f
+incdir+rtl
rtl/pfsc_pkg.sv
rtl/pfsc_seq.sv
rtl/packet_framer_with_sum_checksum.sv
verif/tb_packet_framer_with_sum_checksum.sv
